// ----- hw/rtl/slac_pkg.sv -----
// ----------------------------------------------------------------------------
// slac_pkg
// Shared widths, command and status types for the lag-1 autocorrelation block.
// ----------------------------------------------------------------------------
package slac_pkg;

    // Default parameter values for the top level.
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 24;

    // Running sum widths.
    localparam int SUM_BITS = 40;
    localparam int SQ_BITS  = 56;

    // Result width (signed Q2.14) and quotient bits below saturation.
    localparam int OUT_BITS = 16;
    localparam int QUO_BITS = OUT_BITS - 1;

    // Digit-serial multiplier: a wide multiplicand taken one digit per cycle.
    localparam int MUL_DIG_BITS = 32;
    localparam int MUL_DIGITS   = 3;
    localparam int MUL_A_BITS   = MUL_DIG_BITS * MUL_DIGITS;
    localparam int MUL_B_BITS   = 24;
    localparam int MUL_P_BITS   = MUL_A_BITS + MUL_B_BITS;
    localparam int MUL_CNT_BITS = $clog2(MUL_DIGITS + 1);

    // Widths of the estimate terms.
    localparam int S2_BITS  = 80;
    localparam int CN_BITS  = 80;
    localparam int VAR_BITS = 82;
    localparam int DEN_BITS = 104;
    localparam int NUM_BITS = 105;
    localparam int MAG_BITS = DEN_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(QUO_BITS + 1);

    // Saturation limits of the estimate.
    localparam logic [OUT_BITS-1:0] AC_POS_LIMIT = {1'b0, {(OUT_BITS - 1){1'b1}}};
    localparam logic [OUT_BITS-1:0] AC_NEG_LIMIT = {1'b1, {(OUT_BITS - 1){1'b0}}};

    // Multiplications run by the shared multiplier.
    typedef enum logic [3:0] {
        MUL_XX,
        MUL_PX,
        MUL_SLO,
        MUL_SHI,
        MUL_QN,
        MUL_VN,
        MUL_CN,
        MUL_CNN,
        MUL_S2N
    } mul_op_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_UPDATE,
        S_CHECK_N,
        S_CHECK_VAR,
        S_ABS,
        S_DIV,
        S_DIV_WAIT,
        S_RESULT,
        S_ZERO,
        S_OUT
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    mul_start;
        logic    mul_wb;
        mul_op_t mul_op;
        logic    update;
        logic    abs;
        logic    div_start;
        logic    set_zero;
        logic    set_result;
        logic    load_out;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic few_samples;
        logic var_pos;
    } dp_stat_t;

endpackage

// ----- hw/rtl/streaming_lag1_autocorrelation.sv -----
// ----------------------------------------------------------------------------
// streaming_lag1_autocorrelation
// Each accepted item runs nine passes of the shared multiplier and then the
// divider; with fewer than two samples, or when the variance is not positive,
// the estimate is set to zero instead and the remaining passes are skipped.
// The next item is accepted the cycle after the result is loaded, even if the
// output stalls; until then the input stalls.
// Reset clears the running sums, count, previous sample and all handshakes.
// ----------------------------------------------------------------------------
module streaming_lag1_autocorrelation
    import slac_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [OUT_BITS-1:0]    autocorr,
    output logic                          defined,
    output logic [COUNT_BITS-1:0]         sample_count,
    output logic                          count_full
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    // Sequencer for each item.
    slac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Sums, arithmetic units and result registers.
    slac_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .sample       (sample),
        .autocorr     (autocorr),
        .defined      (defined),
        .sample_count (sample_count),
        .count_full   (count_full)
    );

endmodule

// ----- hw/rtl/slac_mul.sv -----
// ----------------------------------------------------------------------------
// slac_mul
// Digit-serial unsigned multiplier: one 32 x 24 partial product per cycle,
// most significant multiplicand digit first.
// ----------------------------------------------------------------------------
module slac_mul
    import slac_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [MUL_A_BITS-1:0] a,
    input  logic [MUL_B_BITS-1:0] b,
    output logic                  done,
    output logic [MUL_P_BITS-1:0] prod
);

    localparam int PP_BITS = MUL_DIG_BITS + MUL_B_BITS;

    logic [MUL_A_BITS-1:0]   a_reg;
    logic [MUL_B_BITS-1:0]   b_reg;
    logic [MUL_P_BITS-1:0]   acc_reg;
    logic [MUL_P_BITS-1:0]   acc_next;
    logic [MUL_CNT_BITS-1:0] cnt_reg;
    logic                    done_reg;
    logic [MUL_DIG_BITS-1:0] digit;
    logic [PP_BITS-1:0]      pp;

    // Partial product of the top digit, added to the shifted accumulator.
    assign digit    = a_reg[MUL_A_BITS-1 -: MUL_DIG_BITS];
    assign pp       = PP_BITS'(digit) * PP_BITS'(b_reg);
    assign acc_next = {acc_reg[MUL_P_BITS-MUL_DIG_BITS-1:0], {MUL_DIG_BITS{1'b0}}}
                      + MUL_P_BITS'(pp);

    // Digit counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == MUL_CNT_BITS'(1));
            if (start)
            begin
                cnt_reg <= MUL_CNT_BITS'(MUL_DIGITS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Operand and accumulator registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            a_reg   <= {a_reg[MUL_A_BITS-MUL_DIG_BITS-1:0], {MUL_DIG_BITS{1'b0}}};
            acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ----- hw/rtl/slac_div.sv -----
// ----------------------------------------------------------------------------
// slac_div
// Restoring divider giving the Q2.14 quotient magnitude one bit per cycle,
// with an up-front check for results beyond the signed 16-bit range.
// ----------------------------------------------------------------------------
module slac_div
    import slac_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [MAG_BITS-1:0] mag,
    input  logic [DEN_BITS-1:0] den,
    output logic                done,
    output logic                ovf,
    output logic [QUO_BITS-1:0] quo
);

    logic [MAG_BITS-1:0]     rem_reg;
    logic [QUO_BITS-1:0]     quo_reg;
    logic                    ovf_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic                    done_reg;
    logic [MAG_BITS-1:0]     den_ext;
    logic                    ge;
    logic [MAG_BITS-1:0]     diff;

    // One trial subtraction per cycle; the divisor is held by the datapath.
    assign den_ext = MAG_BITS'(den);
    assign ge      = (rem_reg >= den_ext);
    assign diff    = ge ? (rem_reg - den_ext) : rem_reg;

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == DIV_CNT_BITS'(1));
            if (start)
            begin
                cnt_reg <= DIV_CNT_BITS'(QUO_BITS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Remainder, quotient and overflow flag. A quotient of 2^15 or more
    // saturates, which holds exactly when the magnitude reaches twice the
    // divisor.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= mag;
            quo_reg <= '0;
            ovf_reg <= (mag >= {den, 1'b0});
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= {diff[MAG_BITS-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_BITS-2:0], ge};
        end
    end

    assign done = done_reg;
    assign ovf  = ovf_reg;
    assign quo  = quo_reg;

endmodule

// ----- hw/rtl/slac_dp.sv -----
// ----------------------------------------------------------------------------
// slac_dp
// Datapath: running sums, estimate terms, shared multiplier, divider and
// result registers, driven step by step by the controller.
// ----------------------------------------------------------------------------
module slac_dp
    import slac_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ctl_cmd_t                   cmd,
    output dp_stat_t                   stat,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [OUT_BITS-1:0] autocorr,
    output logic                       defined,
    output logic [COUNT_BITS-1:0]      sample_count,
    output logic                       count_full
);

    // Running state.
    logic [SUM_BITS-1:0]    sum_s_reg;
    logic [SQ_BITS-1:0]     sum_q_reg;
    logic [SQ_BITS-1:0]     sum_c_reg;
    logic [SAMPLE_BITS-1:0] prev_reg;
    logic                   have_prev_reg;
    logic [COUNT_BITS-1:0]  count_reg;

    // Per-item working registers.
    logic [SAMPLE_BITS-1:0] x_reg;
    logic [SQ_BITS-1:0]     sq_reg;
    logic [SQ_BITS-1:0]     cr_reg;
    logic [S2_BITS-1:0]     s2_reg;
    logic [VAR_BITS-1:0]    var_reg;
    logic [DEN_BITS-1:0]    den_reg;
    logic [CN_BITS-1:0]     cn_reg;
    logic [NUM_BITS-1:0]    num_reg;
    logic [MAG_BITS-1:0]    mag_reg;
    logic                   neg_reg;
    logic [OUT_BITS-1:0]    res_value_reg;
    logic                   res_def_reg;

    // Output registers.
    logic [OUT_BITS-1:0]    autocorr_reg;
    logic                   defined_reg;
    logic [COUNT_BITS-1:0]  sample_count_reg;
    logic                   count_full_reg;

    // Operand magnitudes.
    logic [SAMPLE_BITS-1:0] x_abs;
    logic [SAMPLE_BITS-1:0] prev_abs;
    logic [SUM_BITS-1:0]    s_abs;
    logic [SQ_BITS-1:0]     q_abs;
    logic [SQ_BITS-1:0]     c_abs;
    logic [MUL_B_BITS-1:0]  n_b;
    logic [MUL_B_BITS-1:0]  nm1_b;

    // Multiplier and divider connections.
    logic [MUL_A_BITS-1:0]  mul_a;
    logic [MUL_B_BITS-1:0]  mul_b;
    logic                   mul_done;
    logic [MUL_P_BITS-1:0]  prod;
    logic [SQ_BITS-1:0]     p_sq;
    logic [VAR_BITS-1:0]    p_var;
    logic [NUM_BITS-1:0]    p_num;
    logic                   px_neg;
    logic                   div_done;
    logic                   div_ovf;
    logic [QUO_BITS-1:0]    quo;
    logic [OUT_BITS-1:0]    quo_ext;
    logic                   upd;

    // Magnitudes of the signed operands.
    assign x_abs    = x_reg[SAMPLE_BITS-1] ? (~x_reg + 1'b1) : x_reg;
    assign prev_abs = prev_reg[SAMPLE_BITS-1] ? (~prev_reg + 1'b1) : prev_reg;
    assign s_abs    = sum_s_reg[SUM_BITS-1] ? (~sum_s_reg + 1'b1) : sum_s_reg;
    assign q_abs    = sum_q_reg[SQ_BITS-1] ? (~sum_q_reg + 1'b1) : sum_q_reg;
    assign c_abs    = sum_c_reg[SQ_BITS-1] ? (~sum_c_reg + 1'b1) : sum_c_reg;
    assign n_b      = MUL_B_BITS'(count_reg);
    assign nm1_b    = MUL_B_BITS'(count_reg - 1'b1);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_op)
            MUL_XX:
            begin
                mul_a = MUL_A_BITS'(x_abs);
                mul_b = MUL_B_BITS'(x_abs);
            end
            MUL_PX:
            begin
                mul_a = MUL_A_BITS'(prev_abs);
                mul_b = MUL_B_BITS'(x_abs);
            end
            MUL_SLO:
            begin
                mul_a = MUL_A_BITS'(s_abs);
                mul_b = s_abs[MUL_B_BITS-1:0];
            end
            MUL_SHI:
            begin
                mul_a = MUL_A_BITS'(s_abs);
                mul_b = MUL_B_BITS'(s_abs[SUM_BITS-1:MUL_B_BITS]);
            end
            MUL_QN:
            begin
                mul_a = MUL_A_BITS'(q_abs);
                mul_b = n_b;
            end
            MUL_VN:
            begin
                mul_a = MUL_A_BITS'(var_reg[VAR_BITS-3:0]);
                mul_b = nm1_b;
            end
            MUL_CN:
            begin
                mul_a = MUL_A_BITS'(c_abs);
                mul_b = n_b;
            end
            MUL_CNN:
            begin
                mul_a = MUL_A_BITS'(cn_reg);
                mul_b = n_b;
            end
            MUL_S2N:
            begin
                mul_a = MUL_A_BITS'(s2_reg);
                mul_b = nm1_b;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    slac_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (prod)
    );

    slac_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .mag   (mag_reg),
        .den   (den_reg),
        .done  (div_done),
        .ovf   (div_ovf),
        .quo   (quo)
    );

    // Product slices; every product is known to fit its slice.
    assign p_sq    = prod[SQ_BITS-1:0];
    assign p_var   = prod[VAR_BITS-1:0];
    assign p_num   = prod[NUM_BITS-1:0];
    assign px_neg  = x_reg[SAMPLE_BITS-1] ^ prev_reg[SAMPLE_BITS-1];
    assign quo_ext = OUT_BITS'(quo);

    // Sums freeze once the count saturates.
    assign upd = ~(&count_reg);

    // Running sums, previous sample and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_s_reg     <= '0;
            sum_q_reg     <= '0;
            sum_c_reg     <= '0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            count_reg     <= '0;
        end
        else if (cmd.update && upd)
        begin
            if (have_prev_reg)
            begin
                sum_c_reg <= sum_c_reg + cr_reg;
            end
            sum_s_reg     <= sum_s_reg
                             + {{(SUM_BITS - SAMPLE_BITS){x_reg[SAMPLE_BITS-1]}}, x_reg};
            sum_q_reg     <= sum_q_reg + sq_reg;
            prev_reg      <= x_reg;
            have_prev_reg <= 1'b1;
            count_reg     <= count_reg + 1'b1;
        end
    end

    // Working registers, written back as each step completes.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg <= sample;
        end

        if (cmd.mul_wb)
        begin
            unique case (cmd.mul_op)
                MUL_XX:  sq_reg  <= p_sq;
                MUL_PX:  cr_reg  <= px_neg ? (~p_sq + 1'b1) : p_sq;
                MUL_SLO: s2_reg  <= prod[S2_BITS-1:0];
                MUL_SHI: s2_reg  <= s2_reg
                                    + {prod[S2_BITS-MUL_B_BITS-1:0], {MUL_B_BITS{1'b0}}};
                MUL_QN:  var_reg <= (sum_q_reg[SQ_BITS-1] ? (~p_var + 1'b1) : p_var)
                                    - VAR_BITS'(s2_reg);
                MUL_VN:  den_reg <= prod[DEN_BITS-1:0];
                MUL_CN:  cn_reg  <= prod[CN_BITS-1:0];
                MUL_CNN: num_reg <= sum_c_reg[SQ_BITS-1] ? (~p_num + 1'b1) : p_num;
                MUL_S2N: num_reg <= num_reg - p_num;
                default: num_reg <= num_reg;
            endcase
        end

        // Sign and magnitude of the numerator.
        if (cmd.abs)
        begin
            neg_reg <= num_reg[NUM_BITS-1];
            mag_reg <= num_reg[NUM_BITS-1] ? (~num_reg + 1'b1) : num_reg;
        end

        // Estimate for this item.
        if (cmd.set_zero)
        begin
            res_value_reg <= '0;
            res_def_reg   <= 1'b0;
        end
        else if (cmd.set_result)
        begin
            if (div_ovf)
            begin
                res_value_reg <= neg_reg ? AC_NEG_LIMIT : AC_POS_LIMIT;
            end
            else
            begin
                res_value_reg <= neg_reg ? (~quo_ext + 1'b1) : quo_ext;
            end
            res_def_reg <= 1'b1;
        end

        // Output item.
        if (cmd.load_out)
        begin
            autocorr_reg     <= res_value_reg;
            defined_reg      <= res_def_reg;
            sample_count_reg <= count_reg;
            count_full_reg   <= &count_reg;
        end
    end

    // Status to the controller.
    assign stat.mul_done    = mul_done;
    assign stat.div_done    = div_done;
    assign stat.few_samples = (count_reg < COUNT_BITS'(2));
    assign stat.var_pos     = ~var_reg[VAR_BITS-1] & (|var_reg);

    assign autocorr     = autocorr_reg;
    assign defined      = defined_reg;
    assign sample_count = sample_count_reg;
    assign count_full   = count_full_reg;

endmodule

// ----- hw/rtl/slac_ctrl.sv -----
// ----------------------------------------------------------------------------
// slac_ctrl
// Controller: sequences the sum update, the estimate multiplications and the
// division for each item, and owns both handshakes.
// ----------------------------------------------------------------------------
module slac_ctrl
    import slac_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output ctl_cmd_t cmd,
    input  dp_stat_t stat
);

    ctl_state_t state_reg;
    ctl_state_t state_next;
    mul_op_t    op_reg;
    mul_op_t    op_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // State, current multiplication and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= MUL_XX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.mul_op     = op_reg;
        in_stall       = 1'b1;

        // The output item leaves when it is taken.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    op_next     = MUL_XX;
                    state_next  = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (stat.mul_done)
                begin
                    cmd.mul_wb = 1'b1;
                    unique case (op_reg)
                        MUL_XX:
                        begin
                            op_next    = MUL_PX;
                            state_next = S_ISSUE;
                        end
                        MUL_PX:  state_next = S_UPDATE;
                        MUL_SLO:
                        begin
                            op_next    = MUL_SHI;
                            state_next = S_ISSUE;
                        end
                        MUL_SHI:
                        begin
                            op_next    = MUL_QN;
                            state_next = S_ISSUE;
                        end
                        MUL_QN:  state_next = S_CHECK_VAR;
                        MUL_VN:
                        begin
                            op_next    = MUL_CN;
                            state_next = S_ISSUE;
                        end
                        MUL_CN:
                        begin
                            op_next    = MUL_CNN;
                            state_next = S_ISSUE;
                        end
                        MUL_CNN:
                        begin
                            op_next    = MUL_S2N;
                            state_next = S_ISSUE;
                        end
                        MUL_S2N: state_next = S_ABS;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_CHECK_N;
            end
            S_CHECK_N:
            begin
                if (stat.few_samples)
                begin
                    state_next = S_ZERO;
                end
                else
                begin
                    op_next    = MUL_SLO;
                    state_next = S_ISSUE;
                end
            end
            S_CHECK_VAR:
            begin
                if (!stat.var_pos)
                begin
                    state_next = S_ZERO;
                end
                else
                begin
                    op_next    = MUL_VN;
                    state_next = S_ISSUE;
                end
            end
            S_ABS:
            begin
                cmd.abs    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                cmd.set_result = 1'b1;
                state_next     = S_OUT;
            end
            S_ZERO:
            begin
                cmd.set_zero = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                // Load only when the output register is empty or being taken.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- tb/sv/streaming_lag1_autocorrelation_checker.sv -----
// ----------------------------------------------------------------------------
// streaming_lag1_autocorrelation_checker
// Watches both channels of the lag-1 autocorrelation block. It keeps its own
// running sums and works out the exact Q2.14 estimate for every accepted
// item. It then compares each accepted result, field by field, with the
// oldest estimate still waiting.
// ----------------------------------------------------------------------------
module streaming_lag1_autocorrelation_checker
    import slac_pkg::*;
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic signed [SAMPLE_BITS_DEF-1:0] sample,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic signed [OUT_BITS-1:0]        autocorr,
    input  logic                              defined,
    input  logic [COUNT_BITS_DEF-1:0]         sample_count,
    input  logic                              count_full,
    output int                                failures,
    output int                                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS = OUT_BITS - 2;
    localparam logic [COUNT_BITS_DEF-1:0] COUNT_MAX = '1;

    // One predicted result item.
    typedef struct packed {
        logic [OUT_BITS-1:0]       autocorr;
        logic                      defined;
        logic [COUNT_BITS_DEF-1:0] sample_count;
        logic                      count_full;
    } estimate_t;

    // Running sums of the predictor, cleared by reset.
    logic signed [SUM_BITS-1:0]        sample_sum;
    logic signed [SQ_BITS-1:0]         square_sum;
    logic signed [SQ_BITS-1:0]         lag_sum;
    logic signed [SAMPLE_BITS_DEF-1:0] last_sample;
    logic                              have_last;
    logic [COUNT_BITS_DEF-1:0]         samples_seen;

    estimate_t pending_estimates[$];
    estimate_t oldest;

    initial
    begin
        failures = 0;
        pending  = 0;
    end

    // Fold one sample into the sums; a saturated count freezes everything.
    task automatic accumulate(input logic signed [SAMPLE_BITS_DEF-1:0] x);
        longint xl;
        longint pl;
        xl = x;
        pl = last_sample;
        if (samples_seen != COUNT_MAX)
        begin
            if (have_last)
                lag_sum = lag_sum + SQ_BITS'(pl * xl);
            sample_sum   = sample_sum + SUM_BITS'(xl);
            square_sum   = square_sum + SQ_BITS'(xl * xl);
            samples_seen = samples_seen + 1'b1;
            last_sample  = x;
            have_last    = 1'b1;
        end
    endtask

    // Exact estimate of the current sums, truncated toward zero and saturated.
    function automatic estimate_t estimate_now();
        logic signed [127:0] n_w;
        logic signed [127:0] s_w;
        logic signed [127:0] q_w;
        logic signed [127:0] c_w;
        logic signed [127:0] s2;
        logic signed [127:0] var_w;
        logic signed [127:0] num;
        logic [127:0]        den;
        logic [127:0]        mag;
        logic [127:0]        quo;
        logic                neg;
        estimate_t           e;
        e.autocorr     = '0;
        e.defined      = 1'b0;
        e.sample_count = samples_seen;
        e.count_full   = (samples_seen == COUNT_MAX);
        n_w   = {{(128 - COUNT_BITS_DEF){1'b0}}, samples_seen};
        s_w   = sample_sum;
        q_w   = square_sum;
        c_w   = lag_sum;
        s2    = s_w * s_w;
        var_w = q_w * n_w - s2;
        // Fewer than two samples or no spread leaves the estimate undefined.
        if (samples_seen >= 2 && var_w > 0)
        begin
            e.defined = 1'b1;
            num = c_w * n_w * n_w - s2 * (n_w - 1);
            den = var_w * (n_w - 1);
            neg = num[127];
            mag = neg ? -num : num;
            mag = mag << FRAC_BITS;
            quo = mag / den;
            if (neg)
                e.autocorr = (quo > 128'(AC_NEG_LIMIT)) ? AC_NEG_LIMIT : -quo[OUT_BITS-1:0];
            else
                e.autocorr = (quo > 128'(AC_POS_LIMIT)) ? AC_POS_LIMIT : quo[OUT_BITS-1:0];
        end
        return e;
    endfunction

    // Report one field that differs from its prediction.
    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            failures++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Score results first, then predict for an item accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_sum   = '0;
            square_sum   = '0;
            lag_sum      = '0;
            last_sample  = '0;
            have_last    = 1'b0;
            samples_seen = '0;
            pending_estimates.delete();
            pending      = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_estimates.size() == 0)
                begin
                    failures++;
                    $display("%0t ns: result with no estimate waiting, expected none, actual %0d",
                             $time, autocorr);
                end
                else
                begin
                    oldest = pending_estimates.pop_front();
                    check_field("autocorr", $signed(oldest.autocorr), autocorr);
                    check_field("defined", oldest.defined, defined);
                    check_field("sample_count", oldest.sample_count, sample_count);
                    check_field("count_full", oldest.count_full, count_full);
                end
            end
            if (in_valid && !in_stall)
            begin
                accumulate(sample);
                pending_estimates.push_back(estimate_now());
            end
            pending = pending_estimates.size();
        end
    end

endmodule

// ----- tb/sv/streaming_lag1_autocorrelation_test.sv -----
// ----------------------------------------------------------------------------
// streaming_lag1_autocorrelation_test
// Drives one long stream of samples into the block: a directed opening with
// the sample extremes, the undefined start and alternating full-scale values,
// then random runs of uniform, small, extreme, trending, alternating and held
// samples under four idling phases. The checker scores every result. The
// 24-bit count cannot saturate within a run of this length.
// ----------------------------------------------------------------------------
module streaming_lag1_autocorrelation_test
    import slac_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 262;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int END_CYCLES      = 200;

    // Shapes of the random sample runs.
    typedef enum int {
        MODE_UNIFORM,
        MODE_SMALL,
        MODE_EXTREME,
        MODE_WALK,
        MODE_ALTERNATE,
        MODE_HOLD
    } pattern_t;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              in_valid  = 1'b0;
    logic                              in_stall;
    logic signed [SAMPLE_BITS_DEF-1:0] sample    = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic signed [OUT_BITS-1:0]        autocorr;
    logic                              defined;
    logic [COUNT_BITS_DEF-1:0]         sample_count;
    logic                              count_full;

    int failures;
    int pending;
    int gap_pct     = 0;
    int stall_pct   = 0;
    int idle_cycles = 0;

    pattern_t                          mode       = MODE_UNIFORM;
    int                                run_left   = 0;
    int                                walk_level = 0;
    logic signed [SAMPLE_BITS_DEF-1:0] last_sent  = '0;

    streaming_lag1_autocorrelation dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .autocorr     (autocorr),
        .defined      (defined),
        .sample_count (sample_count),
        .count_full   (count_full)
    );

    streaming_lag1_autocorrelation_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .autocorr     (autocorr),
        .defined      (defined),
        .sample_count (sample_count),
        .count_full   (count_full),
        .failures     (failures),
        .pending      (pending)
    );

    // 100 MHz clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Receiver stalls at the current rate.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("streaming_lag1_autocorrelation_test: FAIL");
            $finish;
        end
    end

    // Present one sample from a falling edge and hold it until accepted.
    task automatic send_sample(input logic signed [SAMPLE_BITS_DEF-1:0] x);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        sample    <= x;
        last_sent = x;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Stop sending until every predicted result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    // Next random sample; a new run shape is drawn after every 4 to 40 items.
    function automatic logic signed [SAMPLE_BITS_DEF-1:0] next_sample();
        int v;
        if (run_left == 0)
        begin
            mode     = pattern_t'($urandom_range(MODE_HOLD, MODE_UNIFORM));
            run_left = $urandom_range(40, 4);
        end
        run_left--;
        case (mode)
            MODE_UNIFORM:
                v = int'($urandom_range(65535)) - 32768;
            MODE_SMALL:
                v = int'($urandom_range(64)) - 32;
            MODE_EXTREME:
                case ($urandom_range(4))
                    0:       v = 32767;
                    1:       v = -32768;
                    2:       v = -1;
                    3:       v = 1;
                    default: v = 0;
                endcase
            MODE_WALK:
            begin
                // Slowly trending samples give a strongly positive estimate.
                walk_level = walk_level + int'($urandom_range(4000)) - 2000;
                if (walk_level > 32767)
                    walk_level = 32767;
                if (walk_level < -32768)
                    walk_level = -32768;
                v = walk_level;
            end
            MODE_ALTERNATE:
            begin
                // Sign flips on every item push the estimate toward its low end.
                v = int'($urandom_range(32767, 20000));
                if (last_sent >= 0)
                    v = -v - int'($urandom_range(1));
            end
            default:
                v = last_sent;
        endcase
        return SAMPLE_BITS_DEF'(v);
    endfunction

    // Stimulus and verdict.
    initial
    begin
        int directed[$];
        int phase_gap[4];
        int phase_stall[4];
        directed = {32767, 32767, -32768, 32767, -32768, 32767, 0, -1, 1,
                    21845, -21846, 0, 0, -32768, -32768, -32768, 32767, 32767,
                    32767, 100, -100, 12345, -12345};
        phase_gap   = '{0, 56, 0, 27};
        phase_stall = '{0, 0, 56, 27};

        // Reset held, then released on a falling edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening: undefined start, full-scale flips, extremes.
        foreach (directed[k])
            send_sample(SAMPLE_BITS_DEF'(directed[k]));
        drain();

        // Random runs under each idling phase.
        for (int p = 0; p < 4; p++)
        begin
            gap_pct   = phase_gap[p];
            stall_pct = phase_stall[p];
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_sample(next_sample());
            drain();
        end

        stall_pct = 0;
        repeat (END_CYCLES) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("streaming_lag1_autocorrelation_test: PASS");
        else
            $display("streaming_lag1_autocorrelation_test: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/slac_pkg.sv
hw/rtl/slac_mul.sv
hw/rtl/slac_div.sv
hw/rtl/slac_dp.sv
hw/rtl/slac_ctrl.sv
hw/rtl/streaming_lag1_autocorrelation.sv
tb/sv/streaming_lag1_autocorrelation_checker.sv
tb/sv/streaming_lag1_autocorrelation_test.sv
